// ===== hdl/nraf_pkg.sv =====
// Shared types and constants for the NIC register access filter.
// No dependencies; imported by every module in hdl/.
package nraf_pkg;

	localparam int WINDOW_BYTES      = 16384;
	localparam int RING_BYTES        = 4096;
	localparam int RING_STRIDE_BYTES = 4096;

	localparam int NUM_QUEUES = 3;
	localparam int QW         = $clog2(NUM_QUEUES);

	// Register offsets inside the controller window
	localparam logic [31:0] OFF_ECR   = 32'h024;
	localparam logic [31:0] OFF_RCR   = 32'h084;
	localparam logic [31:0] OFF_TCR   = 32'h0C4;
	localparam logic [31:0] OFF_PALR  = 32'h0E4;
	localparam logic [31:0] OFF_PAUR  = 32'h0E8;
	localparam logic [31:0] OFF_RDSR1 = 32'h160;
	localparam logic [31:0] OFF_TDSR1 = 32'h164;
	localparam logic [31:0] OFF_MRBR1 = 32'h168;
	localparam logic [31:0] OFF_RDSR2 = 32'h16C;
	localparam logic [31:0] OFF_TDSR2 = 32'h170;
	localparam logic [31:0] OFF_MRBR2 = 32'h174;
	localparam logic [31:0] OFF_RDSR0 = 32'h180;
	localparam logic [31:0] OFF_TDSR0 = 32'h184;
	localparam logic [31:0] OFF_MRBR0 = 32'h188;
	localparam logic [31:0] OFF_FTRL  = 32'h1B0;
	localparam logic [31:0] OFF_TACC  = 32'h1C0;
	localparam logic [31:0] OFF_RACC  = 32'h1C4;
	localparam logic [31:0] OFF_QOS   = 32'h1F0;

	typedef enum logic [2:0] {
		CFG_NIC_BASE       = 3'd0,
		CFG_RAM_LOW        = 3'd1,
		CFG_RAM_HIGH       = 3'd2,
		CFG_SHADOW_TX_BASE = 3'd3,
		CFG_SHADOW_RX_BASE = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		FWD_NONE  = 2'd0,
		FWD_WRITE = 2'd1,
		FWD_READ  = 2'd2
	} forward_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ADDR = 2'd1,
		ST_NOT_RAM  = 2'd2,
		ST_REFUSED  = 2'd3
	} status_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] bus_address;
		logic [31:0] write_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  forward;
		logic [31:0] dev_address;
		logic [31:0] dev_data;
		logic [31:0] read_data;
		logic [1:0]  status;
	} out_word_t;

	// Decode of one access, from the checker to the top level
	typedef struct packed {
		logic          addr_ok;
		logic          is_base;
		logic          is_tx;
		logic [QW-1:0] queue;
		logic          ring_ok;
		logic          value_ok;
	} decision_t;

endpackage

// ===== hdl/nic_register_access_filter.sv =====
// Top level of the NIC register access filter: input register, checks,
// ring register file and result register. Depends on nraf_pkg,
// nraf_check and nraf_ring_regs.
//
//   channel  direction  handshake               word
//   in       input      in_valid / in_ready     in_word_t  (access)
//   out      output     out_valid / out_ready   out_word_t (decision)
//   cfg      input      cfg_we, cfg_index       cfg_wdata  (32 bits)
//
// Input register, then result register; one word per cycle if out_ready.
// Ring base writes update the register file as the word leaves the input
// register, so the next word already sees the new value.
// Reset clears configuration, kept ring values and both valid bits.
// A stall on out holds the result; the input register keeps filling
// and in_ready drops only when both stages are full.
module nic_register_access_filter import nraf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] nic_base_q;
	logic [31:0] ram_low_q;
	logic [31:0] ram_high_q;
	logic [31:0] shadow_tx_q;
	logic [31:0] shadow_rx_q;

	logic      valid_s1;
	in_word_t  item_s1;
	logic      valid_s2;
	out_word_t result_s2;

	logic        adv_s2;
	decision_t   dec;
	logic        ring_we;
	logic [31:0] ring_rdata;
	logic [31:0] step;
	out_word_t   result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nic_base_q  <= '0;
			ram_low_q   <= '0;
			ram_high_q  <= '0;
			shadow_tx_q <= '0;
			shadow_rx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NIC_BASE:       nic_base_q  <= cfg_wdata;
				CFG_RAM_LOW:        ram_low_q   <= cfg_wdata;
				CFG_RAM_HIGH:       ram_high_q  <= cfg_wdata;
				CFG_SHADOW_TX_BASE: shadow_tx_q <= cfg_wdata;
				CFG_SHADOW_RX_BASE: shadow_rx_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	nraf_check u_check (
		.item     (item_s1),
		.nic_base (nic_base_q),
		.ram_low  (ram_low_q),
		.ram_high (ram_high_q),
		.dec      (dec)
	);

	assign ring_we = adv_s2 && item_s1.operation && dec.addr_ok && dec.is_base
		&& dec.ring_ok;

	nraf_ring_regs u_ring_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ring_we),
		.is_tx  (dec.is_tx),
		.queue  (dec.queue),
		.wdata  (item_s1.write_value),
		.rdata  (ring_rdata)
	);

	assign step = 32'(RING_STRIDE_BYTES) * {{(32-QW){1'b0}}, dec.queue};

	always_comb begin
		result = '0;
		if (!dec.addr_ok) begin
			result.status = ST_BAD_ADDR;
		end else if (item_s1.operation) begin
			if (dec.is_base) begin
				if (!dec.ring_ok) begin
					result.status = ST_NOT_RAM;
				end else begin
					result.forward     = FWD_WRITE;
					result.dev_address = item_s1.bus_address;
					result.dev_data    = (dec.is_tx ? shadow_tx_q : shadow_rx_q) + step;
				end
			end else if (!dec.value_ok) begin
				result.status = ST_REFUSED;
			end else begin
				result.forward     = FWD_WRITE;
				result.dev_address = item_s1.bus_address;
				result.dev_data    = item_s1.write_value;
			end
		end else begin
			if (dec.is_base) begin
				result.read_data = ring_rdata;
			end else begin
				result.forward     = FWD_READ;
				result.dev_address = item_s1.bus_address;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	a_refused_no_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.forward == FWD_NONE)
		else $error("rejected word forwarded");

	a_fwd_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.forward != FWD_NONE |-> out_data.read_data == 32'd0)
		else $error("forwarded word carries read data");

	a_ring_we_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> adv_s2 && valid_s1 && item_s1.operation)
		else $error("ring write without an advancing write");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while stage empty");

	a_load_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> out_valid)
		else $error("advanced word lost");

endmodule

// ===== hdl/nraf_check.sv =====
// Address, ring and value checks for one register access.
// Depends on nraf_pkg.
module nraf_check import nraf_pkg::*; (
	input  in_word_t    item,
	input  logic [31:0] nic_base,
	input  logic [31:0] ram_low,
	input  logic [31:0] ram_high,
	output decision_t   dec
);

	logic [32:0]   addr_ext;
	logic [32:0]   win_end;
	logic [32:0]   ring_last;
	logic [31:0]   off;
	logic [31:0]   v;
	logic          addr_ok;
	logic          ring_ok;
	logic          is_base;
	logic          is_tx;
	logic [QW-1:0] queue;
	logic          value_ok;

	assign addr_ext  = {1'b0, item.bus_address};
	assign win_end   = {1'b0, nic_base} + 33'(WINDOW_BYTES);
	assign v         = item.write_value;
	assign ring_last = {1'b0, v} + 33'(RING_BYTES - 1);
	assign off       = item.bus_address - nic_base;

	// window check is done on 33 bits so the end never wraps
	assign addr_ok = (item.bus_address[1:0] == 2'b00)
		&& (item.bus_address >= nic_base)
		&& (addr_ext + 33'd4 <= win_end);

	assign ring_ok = (v >= ram_low) && (ring_last <= {1'b0, ram_high});

	always_comb begin
		is_base = 1'b1;
		is_tx   = 1'b1;
		queue   = QW'(0);
		case (off)
			OFF_TDSR0: begin is_tx = 1'b1; queue = QW'(0); end
			OFF_TDSR1: begin is_tx = 1'b1; queue = QW'(1); end
			OFF_TDSR2: begin is_tx = 1'b1; queue = QW'(2); end
			OFF_RDSR0: begin is_tx = 1'b0; queue = QW'(0); end
			OFF_RDSR1: begin is_tx = 1'b0; queue = QW'(1); end
			OFF_RDSR2: begin is_tx = 1'b0; queue = QW'(2); end
			default: begin
				is_base = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (off)
			OFF_ECR:  value_ok = (v == 32'h0) || (v == 32'h2) || (v == 32'h112)
				|| (v == 32'h123) || (v == 32'h132);
			OFF_RCR:  value_ok = (v == 32'h47c00064) || (v == 32'h47c00044)
				|| (v == 32'h47c00046) || (v == 32'h0);
			OFF_TCR:  value_ok = (v == 32'h0) || (v == 32'h4);
			OFF_PALR: value_ok = (v == 32'h0019b809);
			OFF_PAUR: value_ok = (v == 32'h96600000) || (v == 32'h9660ffff);
			OFF_MRBR0, OFF_MRBR1, OFF_MRBR2: value_ok = (v == 32'd1984);
			OFF_FTRL: value_ok = (v == 32'h7c0);
			OFF_TACC, OFF_RACC: value_ok = (v == 32'h86);
			OFF_QOS:  value_ok = 1'b0;
			default:  value_ok = 1'b1;
		endcase
	end

	assign dec = {addr_ok, is_base, is_tx, queue, ring_ok, value_ok};

endmodule

// ===== hdl/nraf_ring_regs.sv =====
// Kept guest values of the TX and RX descriptor ring base registers.
// Depends on nraf_pkg.
module nraf_ring_regs import nraf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic          is_tx,
	input  logic [QW-1:0] queue,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] tx_q [NUM_QUEUES];
	logic [31:0] rx_q [NUM_QUEUES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				tx_q[i] <= '0;
				rx_q[i] <= '0;
			end
		end else if (we) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (queue == QW'(i)) begin
					if (is_tx) begin
						tx_q[i] <= wdata;
					end else begin
						rx_q[i] <= wdata;
					end
				end
			end
		end
	end

	always_comb begin
		rdata = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (queue == QW'(i)) begin
				rdata = is_tx ? tx_q[i] : rx_q[i];
			end
		end
	end

endmodule

// ===== sim/nic_register_access_filter_tb.sv =====
// Self-checking testbench for nic_register_access_filter: directed and random bus
// accesses, a per-access firewall predictor, and an in-order results scoreboard.
// Depends on nraf_pkg and the RTL top level; standalone otherwise.
`timescale 1ns / 1ps

module nic_register_access_filter_tb;
	import nraf_pkg::*;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;
	localparam logic [2:0] CFG_SPARE = 3'd7;   // no register behind this index
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	// filter settings as last written, and the ring bases the guest owns
	logic [31:0] win_base = '0, ram_lo = '0, ram_hi = '0, shadow_tx = '0, shadow_rx = '0;
	logic [31:0] kept_tx[3];
	logic [31:0] kept_rx[3];

	out_word_t verdicts[$];
	out_word_t want;
	bit steady = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int accesses_in = 0, accesses_out = 0, settings_loaded = 0;
	int fwd_writes = 0, fwd_reads = 0, local_reads = 0;
	int bad_addr = 0, bad_ring = 0, refused = 0;

	nic_register_access_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: cycle limit reached with %0d words outstanding", $time,
				verdicts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Ring base register slot for a window offset: 0..2, or -1
	function automatic int ring_slot(logic [31:0] off, output logic tx);
		tx = 1'b1;
		case (off)
			OFF_TDSR0: return 0;
			OFF_TDSR1: return 1;
			OFF_TDSR2: return 2;
			default: ;
		endcase
		tx = 1'b0;
		case (off)
			OFF_RDSR0: return 0;
			OFF_RDSR1: return 1;
			OFF_RDSR2: return 2;
			default: return -1;
		endcase
	endfunction

	function automatic logic value_allowed(logic [31:0] off, logic [31:0] v);
		case (off)
			OFF_ECR:  return v == 32'h0 || v == 32'h2 || v == 32'h112 || v == 32'h123 ||
				v == 32'h132;
			OFF_RCR:  return v == 32'h0 || v == 32'h47c00064 || v == 32'h47c00044 ||
				v == 32'h47c00046;
			OFF_TCR:  return v == 32'h0 || v == 32'h4;
			OFF_PALR: return v == 32'h19b809;
			OFF_PAUR: return v == 32'h96600000 || v == 32'h9660ffff;
			OFF_MRBR0, OFF_MRBR1, OFF_MRBR2: return v == 32'd1984;
			OFF_FTRL: return v == 32'h7c0;
			OFF_TACC, OFF_RACC: return v == 32'h86;
			OFF_QOS:  return 1'b0;
			default:  return 1'b1;
		endcase
	endfunction

	// Decision for one access; updates the kept ring bases on accepted writes
	function automatic out_word_t firewall_verdict(in_word_t w);
		out_word_t r;
		logic [32:0] a33, lo33, v33;
		logic [31:0] off;
		logic tx;
		int q;
		r = '0;
		r.forward = FWD_NONE;
		r.status = ST_OK;
		a33 = {1'b0, w.bus_address};
		lo33 = {1'b0, win_base};
		if (w.bus_address[1:0] != 2'b00 || a33 < lo33 ||
				a33 + 33'd4 > lo33 + 33'(WINDOW_BYTES)) begin
			r.status = ST_BAD_ADDR;
			return r;
		end
		off = w.bus_address - win_base;
		q = ring_slot(off, tx);
		if (w.operation == OP_WRITE) begin
			if (q >= 0) begin
				v33 = {1'b0, w.write_value};
				if (v33 < {1'b0, ram_lo} || v33 + 33'(RING_BYTES - 1) > {1'b0, ram_hi}) begin
					r.status = ST_NOT_RAM;
				end else begin
					if (tx) begin
						kept_tx[q] = w.write_value;
						r.dev_data = shadow_tx + 32'(q * RING_STRIDE_BYTES);
					end else begin
						kept_rx[q] = w.write_value;
						r.dev_data = shadow_rx + 32'(q * RING_STRIDE_BYTES);
					end
					r.forward = FWD_WRITE;
					r.dev_address = w.bus_address;
				end
			end else if (!value_allowed(off, w.write_value)) begin
				r.status = ST_REFUSED;
			end else begin
				r.forward = FWD_WRITE;
				r.dev_address = w.bus_address;
				r.dev_data = w.write_value;
			end
		end else if (q >= 0) begin
			r.read_data = tx ? kept_tx[q] : kept_rx[q];
		end else begin
			r.forward = FWD_READ;
			r.dev_address = w.bus_address;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t ns: %s expected %h got %h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// Results are checked before the same edge's input is predicted
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			accesses_out++;
			if (verdicts.size() == 0) begin
				$display("%0t ns: word out with none pending, expected nothing got %h",
					$time, out_data);
				mismatches++;
			end else begin
				want = verdicts.pop_front();
				check_field("forward", 32'(want.forward), 32'(out_data.forward));
				check_field("dev_address", want.dev_address, out_data.dev_address);
				check_field("dev_data", want.dev_data, out_data.dev_data);
				check_field("read_data", want.read_data, out_data.read_data);
				check_field("status", 32'(want.status), 32'(out_data.status));
				case (want.status)
					ST_BAD_ADDR: bad_addr++;
					ST_NOT_RAM:  bad_ring++;
					ST_REFUSED:  refused++;
					default: begin
						if (want.forward == FWD_WRITE) fwd_writes++;
						else if (want.forward == FWD_READ) fwd_reads++;
						else local_reads++;
					end
				endcase
			end
		end
		if (arst_n && in_valid && in_ready) begin
			verdicts.push_back(firewall_verdict(in_data));
			accesses_in++;
		end
	end

	// mostly short pauses, a few long ones
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 92) return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			stall_left <= pause_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_access(in_word_t w);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and let every pending word come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(logic [31:0] nb, logic [31:0] lo, logic [31:0] hi,
			logic [31:0] stx, logic [31:0] srx);
		logic [31:0] vals[5];
		vals = '{nb, lo, hi, stx, srx};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_index_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		// unmapped index must leave everything alone
		cfg_index <= CFG_SPARE;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_base = nb;
		ram_lo = lo;
		ram_hi = hi;
		shadow_tx = stx;
		shadow_rx = srx;
		settings_loaded++;
	endtask

	function automatic in_word_t acc(logic op, logic [31:0] addr, logic [31:0] val);
		in_word_t w;
		w.operation = op;
		w.bus_address = addr;
		w.write_value = val;
		return w;
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 17))
			0:  return OFF_ECR;
			1:  return OFF_RCR;
			2:  return OFF_TCR;
			3:  return OFF_PALR;
			4:  return OFF_PAUR;
			5:  return OFF_RDSR1;
			6:  return OFF_TDSR1;
			7:  return OFF_MRBR1;
			8:  return OFF_RDSR2;
			9:  return OFF_TDSR2;
			10: return OFF_MRBR2;
			11: return OFF_RDSR0;
			12: return OFF_TDSR0;
			13: return OFF_MRBR0;
			14: return OFF_FTRL;
			15: return OFF_TACC;
			16: return OFF_RACC;
			default: return OFF_QOS;
		endcase
	endfunction

	function automatic logic [31:0] allowed_value(logic [31:0] off);
		int k;
		k = $urandom_range(0, 4);
		case (off)
			OFF_ECR:  return k == 0 ? 32'h0 : k == 1 ? 32'h2 : k == 2 ? 32'h112 :
				k == 3 ? 32'h123 : 32'h132;
			OFF_RCR:  return k == 0 ? 32'h0 : k == 1 ? 32'h47c00064 : k == 2 ? 32'h47c00044 :
				32'h47c00046;
			OFF_TCR:  return k[0] ? 32'h4 : 32'h0;
			OFF_PALR: return 32'h19b809;
			OFF_PAUR: return k[0] ? 32'h9660ffff : 32'h96600000;
			OFF_MRBR0, OFF_MRBR1, OFF_MRBR2: return 32'd1984;
			OFF_FTRL: return 32'h7c0;
			OFF_TACC, OFF_RACC: return 32'h86;
			default:  return $urandom;
		endcase
	endfunction

	// ring base inside RAM where one fits, with hits on both edges and just past
	function automatic logic [31:0] ring_value();
		longint unsigned room;
		if (ram_hi < ram_lo || ram_hi - ram_lo < RING_BYTES - 1) return $urandom;
		room = {32'd0, ram_hi - ram_lo} - 64'(RING_BYTES) + 64'd2;
		case ($urandom_range(0, 7))
			0: return ram_lo;
			1: return ram_hi - (RING_BYTES - 1);
			2: return ram_hi - (RING_BYTES - 2);
			default: return ram_lo + 32'({$urandom, $urandom} % room);
		endcase
	endfunction

	function automatic in_word_t random_access();
		in_word_t w;
		logic [31:0] off;
		logic tx;
		int r;
		r = $urandom_range(0, 99);
		w.operation = 1'($urandom_range(0, 1));
		w.write_value = $urandom;
		if (r < 12) begin
			w.bus_address = $urandom;
			return w;
		end
		if (r < 16) begin
			w.bus_address = $urandom_range(0, 1) ? win_base - 4 : win_base + WINDOW_BYTES;
			return w;
		end
		off = (r < 80) ? pick_offset() :
			{30'($urandom_range(0, WINDOW_BYTES / 4 - 1)), 2'b00};
		w.bus_address = win_base + off;
		if ($urandom_range(0, 9) < 7)
			w.write_value = (ring_slot(off, tx) >= 0) ? ring_value() : allowed_value(off);
		return w;
	endfunction

	task automatic random_burst(int n, int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at) wait_idle();
			send_access(random_access());
		end
		wait_idle();
	endtask

	task automatic random_config();
		logic [31:0] nb, lo, hi;
		logic [32:0] t;
		case ($urandom_range(0, 5))
			0: nb = '0;
			1: nb = 32'hFFFF_C000;
			2: nb = $urandom;
			default: nb = $urandom & 32'hFFFF_FFFC;
		endcase
		lo = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				t = {1'b0, lo} + 33'($urandom_range(0, 3 * RING_BYTES));
				hi = t[32] ? 32'hFFFF_FFFF : t[31:0];
			end
			2: hi = $urandom;
			default: begin
				lo = lo & 32'hFFF0_0000;
				hi = lo | 32'h00FF_FFFF;
			end
		endcase
		load_config(nb, lo, hi, $urandom_range(0, 7) == 0 ? 32'hFFFF_FFFF : $urandom, $urandom);
	endtask

	// reset settings: window at 0, RAM too small for any ring
	task automatic test_reset_state();
		send_access(acc(OP_READ, OFF_TDSR0, 32'hFFFF_FFFF));
		send_access(acc(OP_WRITE, OFF_TDSR0, 32'h0));
		send_access(acc(OP_READ, 32'h0, 32'h0));
		send_access(acc(OP_WRITE, 32'(WINDOW_BYTES - 4), 32'hFFFF_FFFF));
		send_access(acc(OP_READ, 32'hFFFF_FFFF, 32'h0));
		wait_idle();
	endtask

	task automatic test_whitelists();
		logic [31:0] b;
		load_config(32'h4000_0000, 32'h8000_0000, 32'h8FFF_FFFF, 32'h2000_0000, 32'hFFFF_F000);
		b = win_base;
		send_access(acc(OP_WRITE, b + OFF_ECR, 32'h112));
		send_access(acc(OP_WRITE, b + OFF_ECR, 32'h5));
		send_access(acc(OP_WRITE, b + OFF_RCR, 32'h47c00046));
		send_access(acc(OP_WRITE, b + OFF_TCR, 32'h4));
		send_access(acc(OP_WRITE, b + OFF_PALR, 32'h19b808));
		send_access(acc(OP_WRITE, b + OFF_PAUR, 32'h9660ffff));
		send_access(acc(OP_WRITE, b + OFF_MRBR1, 32'd1984));
		send_access(acc(OP_WRITE, b + OFF_FTRL, 32'h7c0));
		send_access(acc(OP_WRITE, b + OFF_TACC, 32'h87));
		send_access(acc(OP_WRITE, b + OFF_QOS, 32'h0));
		send_access(acc(OP_READ, b + OFF_QOS, 32'h0));
		wait_idle();
	endtask

	// RX shadow of queue 1 wraps past the top of the address space
	task automatic test_ring_bases();
		logic [31:0] b;
		b = win_base;
		send_access(acc(OP_WRITE, b + OFF_TDSR0, 32'h8000_0000));
		send_access(acc(OP_WRITE, b + OFF_RDSR1, 32'h8FFF_F000));
		send_access(acc(OP_WRITE, b + OFF_RDSR2, 32'h8FFF_F001));
		send_access(acc(OP_WRITE, b + OFF_TDSR2, 32'h7FFF_FFFC));
		send_access(acc(OP_WRITE, b + OFF_TDSR1, 32'hFFFF_FFFF));
		send_access(acc(OP_READ, b + OFF_TDSR0, 32'h0));
		send_access(acc(OP_READ, b + OFF_RDSR1, 32'h0));
		send_access(acc(OP_READ, b + OFF_TDSR2, 32'h0));
		send_access(acc(OP_READ, b + 2, 32'h0));
		send_access(acc(OP_READ, b - 4, 32'h0));
		send_access(acc(OP_READ, b + WINDOW_BYTES, 32'h0));
		wait_idle();
	endtask

	// window ends exactly at 2^32; a ring may not run past it
	task automatic test_window_top();
		load_config(32'hFFFF_C000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_access(acc(OP_WRITE, win_base + OFF_TDSR2, 32'hFFFF_F000));
		send_access(acc(OP_WRITE, win_base + OFF_RDSR0, 32'hFFFF_F001));
		send_access(acc(OP_READ, 32'hFFFF_FFFC, 32'h0));
		wait_idle();
	endtask

	task automatic test_empty_ram();
		load_config(32'h0, 32'hFFFF_FFFF, 32'h0, $urandom, $urandom);
		random_burst(150, -1);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 6; p++) begin
			random_config();
			steady = (p == 2);
			random_burst(300, p == 3 ? 150 : -1);
			steady = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			kept_tx[i] = '0;
			kept_rx[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_whitelists();
		test_ring_bases();
		test_window_top();
		test_empty_ram();
		test_random_settings();
		$display("Checked %0d of %0d accesses over %0d filter settings", accesses_out,
			accesses_in, settings_loaded);
		$display("fwd writes %0d, fwd reads %0d, local reads %0d",
			fwd_writes, fwd_reads, local_reads);
		$display("rejected addr/ring/value %0d/%0d/%0d", bad_addr, bad_ring, refused);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== nic_register_access_filter.f =====
hdl/nraf_pkg.sv
hdl/nraf_check.sv
hdl/nraf_ring_regs.sv
hdl/nic_register_access_filter.sv
sim/nic_register_access_filter_tb.sv
